// ===== hdl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// shared types and constants of the triangle setup and split block
// ----------------------------------------------------------------------------
package tss_pkg;

    // fraction bits of the interpolation ratio k
    localparam int KBITS = 30;

    typedef enum logic [2:0] {
        KIND_TOP    = 3'd0,
        KIND_BOTTOM = 3'd1,
        KIND_LEFT   = 3'd2,
        KIND_RIGHT  = 3'd3,
        KIND_DEGEN  = 3'd4
    } t_kind;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [30:0] rw;
        logic        [23:0] rgb;
        logic        [15:0] u;
        logic        [15:0] v;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_vtx;

    // one sorted triangle as handed from front to back
    typedef struct packed {
        t_vtx [2:0] v;
        logic       level;
        t_kind      kind;
    } t_tri;

    typedef struct packed {
        logic        start;
        logic [62:0] num;
        logic [62:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [29:0] quot;
    } t_div_rsp;

endpackage

// ===== hdl/tss_in_if.sv =====
// ----------------------------------------------------------------------------
// tss_in_if
// vertex channel: valid, ready and one vertex
// ----------------------------------------------------------------------------
interface tss_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [30:0] recip_w;
    logic        [23:0] rgb;
    logic        [15:0] tex_u;
    logic        [15:0] tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;

    modport source (output valid, pos_x, pos_y, pos_z, recip_w, rgb, tex_u, tex_v,
                    norm_x, norm_y, norm_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, recip_w, rgb, tex_u, tex_v,
                    norm_x, norm_y, norm_z, output ready);
endinterface

// ===== hdl/tss_out_if.sv =====
// ----------------------------------------------------------------------------
// tss_out_if
// result channel: valid, ready and one vertex or split point
// ----------------------------------------------------------------------------
interface tss_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [30:0] out_recip_w;
    logic        [23:0] out_rgb;
    logic        [15:0] out_u;
    logic        [15:0] out_v;
    logic signed [15:0] out_nx;
    logic signed [15:0] out_ny;
    logic signed [15:0] out_nz;
    logic        [2:0]  tri_kind;
    logic               last;

    modport source (output valid, out_x, out_y, out_z, out_recip_w, out_rgb, out_u, out_v,
                    out_nx, out_ny, out_nz, tri_kind, last, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_recip_w, out_rgb, out_u, out_v,
                    out_nx, out_ny, out_nz, tri_kind, last, output ready);
endinterface

// ===== hdl/tss_front.sv =====
// ----------------------------------------------------------------------------
// tss_front
// gathers three vertices, sorts them by y and types level triangles
// ----------------------------------------------------------------------------
module tss_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tss_in_if.sink        i_vtx,
    input  logic          i_full,
    output logic          o_push,
    output tss_pkg::t_tri o_tri
);

    logic [1:0]    r_cnt;
    tss_pkg::t_vtx r_buf [0:1];
    tss_pkg::t_vtx cur;
    logic          accept;

    assign cur.x   = i_vtx.pos_x;
    assign cur.y   = i_vtx.pos_y;
    assign cur.z   = i_vtx.pos_z;
    assign cur.rw  = i_vtx.recip_w;
    assign cur.rgb = i_vtx.rgb;
    assign cur.u   = i_vtx.tex_u;
    assign cur.v   = i_vtx.tex_v;
    assign cur.nx  = i_vtx.norm_x;
    assign cur.ny  = i_vtx.norm_y;
    assign cur.nz  = i_vtx.norm_z;

    assign i_vtx.ready = (r_cnt != 2'd2) || !i_full;
    assign accept      = i_vtx.valid && i_vtx.ready;
    assign o_push      = accept && (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_cnt != 2'd2) begin
            r_buf[r_cnt[0]] <= cur;
        end
    end

    // stable compare/swap network, then level pair ordering by x
    always_comb begin
        tss_pkg::t_vtx a, b, c, t;
        a = r_buf[0];
        b = r_buf[1];
        c = cur;
        t = a;
        if (a.y > b.y) begin
            t = a; a = b; b = t;
        end
        if (b.y > c.y) begin
            t = b; b = c; c = t;
            if (a.y > b.y) begin
                t = a; a = b; b = t;
            end
        end
        o_tri.level = 1'b1;
        o_tri.kind  = tss_pkg::KIND_TOP;
        if (a.y == b.y) begin
            if (a.x > b.x) begin
                t = a; a = b; b = t;
            end
        end else if (b.y == c.y) begin
            o_tri.kind = tss_pkg::KIND_BOTTOM;
            if (b.x > c.x) begin
                t = b; b = c; c = t;
            end
        end else begin
            o_tri.level = 1'b0;
            o_tri.kind  = tss_pkg::KIND_LEFT;
        end
        o_tri.v[0] = a;
        o_tri.v[1] = b;
        o_tri.v[2] = c;
    end

endmodule

// ===== hdl/tss_queue.sv =====
// ----------------------------------------------------------------------------
// tss_queue
// two-entry triangle queue between front and back
// ----------------------------------------------------------------------------
module tss_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tss_pkg::t_tri i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output tss_pkg::t_tri o_data
);

    tss_pkg::t_tri r_mem [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/tss_div.sv =====
// ----------------------------------------------------------------------------
// tss_div
// restoring divider, one quotient bit a cycle, fraction of num/den below one
// ----------------------------------------------------------------------------
module tss_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tss_pkg::t_div_req i_req,
    output tss_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [62:0] r_rem;
    logic [62:0] r_den;
    logic [29:0] r_q;
    logic [63:0] rem2;
    logic        ge;
    logic [63:0] sub;

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};
    assign sub  = rem2 - {1'b0, r_den};

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= ge ? sub[62:0] : rem2[62:0];
                r_q   <= {r_q[28:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(tss_pkg::KBITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/tss_back.sv =====
// ----------------------------------------------------------------------------
// tss_back
// computes the split point with a shared multiplier and divider, emits results
// ----------------------------------------------------------------------------
module tss_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  tss_pkg::t_tri i_q_tri,
    output logic          o_q_pop,
    tss_out_if.source     o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_KL, S_KLW, S_MUL, S_ACC, S_PM1, S_PM2, S_PCHK, S_PDIV, S_KIND, S_EMIT
    } t_state;

    localparam logic [30:0] K_ONE = 31'(1) << tss_pkg::KBITS;

    t_state              r_state;
    tss_pkg::t_tri       r_tri;
    tss_pkg::t_vtx       r_s;
    tss_pkg::t_kind      r_kind;
    logic [3:0]          r_op;
    logic [1:0]          r_idx;
    logic [30:0]         r_kl;
    logic [30:0]         r_k;
    logic signed [64:0]  r_prod;
    logic signed [64:0]  r_num;
    logic                r_ov;
    tss_pkg::t_vtx       r_out;
    tss_pkg::t_kind      r_okind;
    logic                r_olast;

    tss_pkg::t_div_req   div_req;
    tss_pkg::t_div_rsp   div_rsp;

    logic signed [32:0]  base;
    logic signed [32:0]  top;
    logic signed [32:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic signed [34:0]  acc;
    logic [7:0]          chan;
    logic                out_free;
    logic signed [64:0]  un;
    logic signed [64:0]  ud;
    logic                sign_ok;
    logic signed [32:0]  dy1;
    logic signed [32:0]  dy2;
    tss_pkg::t_vtx       v0;
    tss_pkg::t_vtx       v1;
    tss_pkg::t_vtx       v2;

    assign v0 = r_tri.v[0];
    assign v1 = r_tri.v[1];
    assign v2 = r_tri.v[2];

    tss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_ov || o_res.ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    assign dy1 = {v1.y[31], v1.y} - {v0.y[31], v0.y};
    assign dy2 = {v2.y[31], v2.y} - {v0.y[31], v0.y};

    // interpolation endpoints picked by step
    always_comb begin
        case (r_op)
            4'd0:    begin base = {v0.x[31], v0.x}; top = {v2.x[31], v2.x}; end
            4'd1:    begin base = {v0.z[31], v0.z}; top = {v2.z[31], v2.z}; end
            4'd2:    begin base = {2'b0, v0.rw};    top = {2'b0, v2.rw};    end
            4'd3:    begin base = {{17{v0.nx[15]}}, v0.nx}; top = {{17{v2.nx[15]}}, v2.nx}; end
            4'd4:    begin base = {{17{v0.ny[15]}}, v0.ny}; top = {{17{v2.ny[15]}}, v2.ny}; end
            4'd5:    begin base = {{17{v0.nz[15]}}, v0.nz}; top = {{17{v2.nz[15]}}, v2.nz}; end
            4'd6:    begin base = {17'b0, v0.u}; top = {17'b0, v2.u}; end
            4'd7:    begin base = {17'b0, v0.v}; top = {17'b0, v2.v}; end
            4'd8:    begin base = {25'b0, v0.rgb[23:16]}; top = {25'b0, v2.rgb[23:16]}; end
            4'd9:    begin base = {25'b0, v0.rgb[15:8]};  top = {25'b0, v2.rgb[15:8]};  end
            default: begin base = {25'b0, v0.rgb[7:0]};   top = {25'b0, v2.rgb[7:0]};   end
        endcase
    end

    // multiplier operands: lerp steps or the two perspective products
    always_comb begin
        if (r_state == S_PM1) begin
            mul_a = {2'b0, v0.rw} - {2'b0, r_s.rw};
            mul_b = {1'b0, v2.rw};
        end else if (r_state == S_PM2) begin
            mul_a = {2'b0, v0.rw} - {2'b0, v2.rw};
            mul_b = {1'b0, r_s.rw};
        end else begin
            mul_a = top - base;
            mul_b = {1'b0, (r_op < 4'd3) ? r_kl : r_k};
        end
    end

    assign acc  = {{2{base[32]}}, base} + r_prod[64:30];
    assign chan = acc[34] ? 8'd0 : ((acc > 35'sd255) ? 8'd255 : acc[7:0]);

    assign un      = r_num[64] ? -r_num : r_num;
    assign ud      = r_prod[64] ? -r_prod : r_prod;
    assign sign_ok = (!r_num[64] && !r_prod[64] && (r_prod != 65'sd0))
                  || ((r_num[64] || (r_num == 65'sd0)) && r_prod[64]);

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = un[62:0];
        div_req.den   = ud[62:0];
        if (r_state == S_KL) begin
            div_req.start = 1'b1;
            div_req.num   = {30'b0, dy1};
            div_req.den   = {30'b0, dy2};
        end else if (r_state == S_PCHK && sign_ok && un < ud) begin
            div_req.start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_op    <= 4'd0;
            r_idx   <= 2'd0;
        end else begin
            // result register loads on an emit step, clears once taken
            r_ov <= ((r_state == S_EMIT) && out_free) || (r_ov && !o_res.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_tri  <= i_q_tri;
                        r_kind <= i_q_tri.kind;
                        r_idx  <= 2'd0;
                        r_state <= i_q_tri.level ? S_EMIT : S_KL;
                    end
                end
                S_KL: r_state <= S_KLW;
                S_KLW: begin
                    if (div_rsp.done) begin
                        r_kl    <= {1'b0, div_rsp.quot};
                        r_op    <= 4'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_op)
                        4'd0:    r_s.x  <= acc[31:0];
                        4'd1:    r_s.z  <= acc[31:0];
                        4'd2:    r_s.rw <= acc[30:0];
                        4'd3:    r_s.nx <= acc[15:0];
                        4'd4:    r_s.ny <= acc[15:0];
                        4'd5:    r_s.nz <= acc[15:0];
                        4'd6:    r_s.u  <= acc[15:0];
                        4'd7:    r_s.v  <= acc[15:0];
                        4'd8:    r_s.rgb[23:16] <= chan;
                        4'd9:    r_s.rgb[15:8]  <= chan;
                        default: r_s.rgb[7:0]   <= chan;
                    endcase
                    if (r_op == 4'd2) begin
                        r_state <= S_PM1;
                    end else if (r_op == 4'd10) begin
                        r_state <= S_KIND;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_PM1: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_PM2;
                end
                S_PM2: begin
                    r_num   <= r_prod;
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    r_op <= 4'd3;
                    if (!sign_ok || un > ud) begin
                        r_k     <= r_kl;
                        r_state <= S_MUL;
                    end else if (un == ud) begin
                        r_k     <= K_ONE;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (div_rsp.done) begin
                        r_k     <= {1'b0, div_rsp.quot};
                        r_state <= S_MUL;
                    end
                end
                S_KIND: begin
                    r_s.y <= v1.y;
                    if (v1.x > r_s.x)      r_kind <= tss_pkg::KIND_LEFT;
                    else if (v1.x < r_s.x) r_kind <= tss_pkg::KIND_RIGHT;
                    else                   r_kind <= tss_pkg::KIND_DEGEN;
                    r_idx   <= 2'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_okind <= r_kind;
                        case (r_idx)
                            2'd0:    r_out <= v0;
                            2'd1:    r_out <= v1;
                            2'd2:    r_out <= v2;
                            default: r_out <= r_s;
                        endcase
                        r_olast <= r_tri.level ? (r_idx == 2'd2) : (r_idx == 2'd3);
                        if (r_tri.level ? (r_idx == 2'd2) : (r_idx == 2'd3)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.out_x       = r_out.x;
    assign o_res.out_y       = r_out.y;
    assign o_res.out_z       = r_out.z;
    assign o_res.out_recip_w = r_out.rw;
    assign o_res.out_rgb     = r_out.rgb;
    assign o_res.out_u       = r_out.u;
    assign o_res.out_v       = r_out.v;
    assign o_res.out_nx      = r_out.nx;
    assign o_res.out_ny      = r_out.ny;
    assign o_res.out_nz      = r_out.nz;
    assign o_res.tri_kind    = r_okind;
    assign o_res.last        = r_olast;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy with no triangle in work");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KIND) |-> (r_k <= K_ONE))
        else $error("interpolation ratio above one");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_olast == 1'b0 && r_idx == 2'd3) |=>
        (r_state == S_IDLE))
        else $error("split point not the final result");
`endif

endmodule

// ===== hdl/triangle_setup_split.sv =====
// ----------------------------------------------------------------------------
// triangle_setup_split
// sorts a triangle by y and splits it at the middle vertex for scanline fill
// ----------------------------------------------------------------------------
// usage
//   i_vtx takes one vertex per transfer; every third transfer closes a
//   triangle. o_res gives the three vertices sorted by ascending y, then
//   for a non-level triangle the split point on the long edge at the
//   middle y. tri_kind is the same on every result, last marks the final
//   one.
// timing
//   the first two vertices are taken at one per cycle. a level triangle
//   goes straight to output. a split triangle waits on the shared
//   restoring divider (the linear ratio, then the perspective ratio when
//   needed) and on one shared multiplier doing eleven interpolations,
//   each a multiply step and an accumulate step.
//   a two-entry queue holds sorted triangles, so the next triangle's
//   vertices are taken while the back end is still working.
// reset
//   i_rst_n low clears the vertex count, the queue and the output valid.
// stall
//   while o_res.ready is low the result register holds; work stops at the
//   next result, the queue fills and i_vtx.ready drops on a third vertex.
// ----------------------------------------------------------------------------
module triangle_setup_split (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tss_in_if.sink    i_vtx,
    tss_out_if.source o_res
);

    logic          push;
    logic          pop;
    logic          q_valid;
    logic          q_full;
    tss_pkg::t_tri f_tri;
    tss_pkg::t_tri q_tri;

    // front: vertex gathering, sort and level typing
    tss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_vtx),
        .i_full  (q_full),
        .o_push  (push),
        .o_tri   (f_tri)
    );

    // queue of sorted triangles
    tss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_tri),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_tri)
    );

    // back: split point arithmetic and result output
    tss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_tri   (q_tri),
        .o_q_pop   (pop),
        .o_res     (o_res)
    );

endmodule
